@@ hdl/gregorian_date_offset_assert.svh @@
// Assertion macros for the Gregorian date offset block.
// Included by the top level; no other dependencies.
`ifndef GREGORIAN_DATE_OFFSET_ASSERT_SVH
`define GREGORIAN_DATE_OFFSET_ASSERT_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define GDO_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define GDO_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/gdo_pkg.sv @@
// Shared types, constants and calendar helper functions for the date offset block.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package gdo_pkg;

  // Payload field widths.
  localparam int YEAR_W    = 14;
  localparam int MONTH_W   = 4;
  localparam int DAY_W     = 5;
  localparam int WEEKDAY_W = 3;

  // Internal counter widths.
  localparam int REM_W = 15;  // start year plus one era, before reduction
  localparam int YOE_W = 9;   // year within the 400-year era
  localparam int W7_W  = 3;   // residue modulo 7
  localparam int DOY_W = 9;   // day of a March-based year

  // Calendar constants.
  localparam int ERA_DAYS        = 146097;
  localparam int ERA_YEARS       = 400;
  localparam int YEAR_DAYS       = 365;
  localparam int CENTURY         = 100;
  localparam int FEB_DAYS        = 28;
  localparam int MONTHS_PER_YEAR = 12;
  localparam int MP_BASE_MONTH   = 3;   // March opens the internal year
  localparam int MP_JAN          = 10;  // internal index of January
  localparam int WEEK_DAYS       = 7;
  localparam int WEEKDAY_BIAS    = 3;   // 1 March of year 0 was a Wednesday
  localparam int YEAR_MIN        = 1;
  localparam int YEAR_MAX        = 9999;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASE,
    ST_PRE,
    ST_ERA,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } state_t;

  // True when the February that closes March-based year yoe has 29 days.
  function automatic logic leap_after(input logic [YOE_W-1:0] yoe);
    logic [YOE_W-1:0] c;
    c = yoe + YOE_W'(1);
    return (c[1:0] == 2'b00) && (c != YOE_W'(CENTURY)) &&
           (c != YOE_W'(2 * CENTURY)) && (c != YOE_W'(3 * CENTURY));
  endfunction

  // Length of internal month mp (0 is March, 11 is February).
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] mp,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (mp)
      4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd10: len = 5'd31;
      4'd1, 4'd3, 4'd6, 4'd8:                    len = 5'd30;
      4'd11:   len = DAY_W'(FEB_DAYS) + DAY_W'(leap);
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // First day of internal month mp, counted from 1 March.
  function automatic logic [DOY_W-1:0] march_doy(input logic [MONTH_W-1:0] mp);
    logic [DOY_W-1:0] doy;
    case (mp)
      4'd0:    doy = 9'd0;
      4'd1:    doy = 9'd31;
      4'd2:    doy = 9'd61;
      4'd3:    doy = 9'd92;
      4'd4:    doy = 9'd122;
      4'd5:    doy = 9'd153;
      4'd6:    doy = 9'd184;
      4'd7:    doy = 9'd214;
      4'd8:    doy = 9'd245;
      4'd9:    doy = 9'd275;
      4'd10:   doy = 9'd306;
      4'd11:   doy = 9'd337;
      default: doy = 9'd0;
    endcase
    return doy;
  endfunction

  // Adds a small step (at most 3) to a residue modulo 7.
  function automatic logic [W7_W-1:0] add_mod7(input logic [W7_W-1:0] w,
                                               input logic [W7_W-1:0] k);
    logic [W7_W:0] s;
    s = {1'b0, w} + {1'b0, k};
    if (s >= (W7_W + 1)'(WEEK_DAYS)) begin
      s = s - (W7_W + 1)'(WEEK_DAYS);
    end
    return s[W7_W-1:0];
  endfunction

  // Reduces a value below 42 modulo 7.
  function automatic logic [W7_W-1:0] wrap_mod7(input logic [5:0] v);
    logic [5:0] s;
    s = v;
    for (int i = 0; i < 5; i++) begin
      if (s >= 6'(WEEK_DAYS)) begin
        s = s - 6'(WEEK_DAYS);
      end
    end
    return s[W7_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hdl/gdo_in_if.sv @@
// Input channel of the date offset block: starting date and signed day offset.
// Depends on gdo_pkg for the field widths.
`default_nettype none

interface gdo_in_if #(
  parameter int OFFSET_BITS = 21
);
  import gdo_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [YEAR_W-1:0]             start_year;
  logic [MONTH_W-1:0]            start_month;
  logic [DAY_W-1:0]              start_day;
  logic signed [OFFSET_BITS-1:0] day_offset;

  modport source (
    output valid, start_year, start_month, start_day, day_offset,
    input  ready
  );

  modport sink (
    input  valid, start_year, start_month, start_day, day_offset,
    output ready
  );
endinterface

`default_nettype wire

@@ hdl/gdo_out_if.sv @@
// Output channel of the date offset block: resulting date, weekday and range flag.
// Depends on gdo_pkg for the field widths.
`default_nettype none

interface gdo_out_if;
  import gdo_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [YEAR_W-1:0]    result_year;
  logic [MONTH_W-1:0]   result_month;
  logic [DAY_W-1:0]     result_day;
  logic [WEEKDAY_W-1:0] weekday;
  logic                 year_out_of_range;

  modport source (
    output valid, result_year, result_month, result_day, weekday, year_out_of_range,
    input  ready
  );

  modport sink (
    input  valid, result_year, result_month, result_day, weekday, year_out_of_range,
    output ready
  );
endinterface

`default_nettype wire

@@ hdl/gregorian_date_offset.sv @@
// Top level of the Gregorian date offset block: sequencer and shared day-count adder.
// Depends on gdo_pkg, gdo_in_if, gdo_out_if and gregorian_date_offset_assert.svh.
//
//   Channel    Dir  Handshake     Carries
//   date_in    in   valid/ready   start_year, start_month, start_day, day_offset
//   date_out   out  valid/ready   result_year, result_month, result_day, weekday,
//                                 year_out_of_range
//
// After acceptance the sequencer reduces the March-based start year Y (one less in January
// and February) modulo 400, counts Y mod 400 years of weekday residue, then walks at most 8
// 146097-day era steps, at most 399 year steps and at most 11 month steps before date_in is
// ready again. All day-count steps share one TW-bit adder.
// date_in is ready only while the sequencer is idle; a finished result sits in the output
// register, so the next transaction is taken while date_out stalls.
// Reset (rst, synchronous) returns the sequencer to idle and empties the output register.
`default_nettype none

`include "gregorian_date_offset_assert.svh"

module gregorian_date_offset #(
  parameter int OFFSET_BITS = 21
) (
  input  logic       clk,
  input  logic       rst,
  gdo_in_if.sink     date_in,
  gdo_out_if.source  date_out
);
  import gdo_pkg::*;

  // Year register holds the start year plus the offset in years, with sign.
  localparam int YW = ((OFFSET_BITS - 9 > YEAR_W) ? OFFSET_BITS - 9 : YEAR_W) + 2;
  // Day count register holds the offset plus one era of headroom.
  localparam int TW = ((OFFSET_BITS > 18) ? OFFSET_BITS : 18) + 2;

  localparam logic signed [TW-1:0] T_ERA  = TW'(ERA_DAYS);
  localparam logic signed [YW-1:0] Y_ERA  = YW'(ERA_YEARS);
  localparam logic signed [YW-1:0] Y_ONE  = YW'(1);
  localparam logic signed [YW-1:0] Y_LO   = YW'(YEAR_MIN);
  localparam logic signed [YW-1:0] Y_HI   = YW'(YEAR_MAX);

  state_t state, state_next;

  logic signed [TW-1:0] t;      // days into the current internal year or month
  logic signed [YW-1:0] y_cur;  // March-based year
  logic [REM_W-1:0]     rem;    // start year reduced modulo 400
  logic [YOE_W-1:0]     yoe;    // year within the era
  logic [W7_W-1:0]      w;      // weekday residue of the current year or month start
  logic [MONTH_W-1:0]   mp;     // internal month, 0 is March

  logic accept;
  logic out_load;
  logic out_valid;

  // Start date decode.
  logic [MONTH_W-1:0]            m_clamp;
  logic                          early;
  logic [MONTH_W-1:0]            mp0;
  logic signed [DOY_W+1:0]       start_doy;
  logic signed [OFFSET_BITS-1:0] off_raw;
  logic signed [TW-1:0]          t0;
  logic signed [YW-1:0]          y0;
  logic [REM_W-1:0]              rem0;

  assign accept  = date_in.valid && date_in.ready;
  assign off_raw = date_in.day_offset;

  always_comb begin
    if (date_in.start_month == '0) begin
      m_clamp = MONTH_W'(1);
    end else if (date_in.start_month > MONTH_W'(MONTHS_PER_YEAR)) begin
      m_clamp = MONTH_W'(MONTHS_PER_YEAR);
    end else begin
      m_clamp = date_in.start_month;
    end
    early = (m_clamp < MONTH_W'(MP_BASE_MONTH));
    if (early) begin
      mp0 = m_clamp + MONTH_W'(MONTHS_PER_YEAR - MP_BASE_MONTH);
    end else begin
      mp0 = m_clamp - MONTH_W'(MP_BASE_MONTH);
    end
    start_doy = signed'((DOY_W + 2)'(march_doy(mp0))) +
                signed'((DOY_W + 2)'(date_in.start_day)) - (DOY_W + 2)'(1);
    t0   = TW'(start_doy) + TW'(off_raw);
    y0   = signed'(YW'(date_in.start_year) - YW'(early));
    rem0 = REM_W'(date_in.start_year) + REM_W'(ERA_YEARS) - REM_W'(early);
  end

  // Calendar lengths for the current position.
  logic               leap_cur;
  logic [DOY_W-1:0]   ylen;
  logic [DAY_W-1:0]   mlen;
  logic [W7_W-1:0]    yadv;
  logic [W7_W-1:0]    madv;

  assign leap_cur = leap_after(yoe);
  assign ylen     = DOY_W'(YEAR_DAYS) + DOY_W'(leap_cur);
  assign mlen     = month_len(mp, leap_cur);
  assign yadv     = W7_W'(leap_cur) + W7_W'(1);
  assign madv     = W7_W'(mlen - DAY_W'(FEB_DAYS));

  // Shared adder: adds one era forward when the count is negative, else tries to
  // take away one era, one year or one month; the step is taken when nothing goes negative.
  logic signed [TW-1:0] opnd;
  logic signed [TW-1:0] sum;
  logic                 t_neg;
  logic                 take;

  assign t_neg = t[TW-1];

  always_comb begin
    case (state)
      ST_ERA:   opnd = t_neg ? T_ERA : -T_ERA;
      ST_YEAR:  opnd = -signed'(TW'(ylen));
      ST_MONTH: opnd = -signed'(TW'(mlen));
      default:  opnd = '0;
    endcase
    sum  = t + opnd;
    take = ((state == ST_ERA) && t_neg) || !sum[TW-1];
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept) state_next = ST_BASE;
      ST_BASE:  if (rem < REM_W'(ERA_YEARS)) state_next = ST_PRE;
      ST_PRE:   if (yoe == rem[YOE_W-1:0]) state_next = ST_ERA;
      ST_ERA:   if (!take) state_next = ST_YEAR;
      ST_YEAR:  if (!take) state_next = ST_MONTH;
      ST_MONTH: if (!take) state_next = ST_DONE;
      ST_DONE:  if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Handshake outputs of the sequencer.
  always_comb begin
    date_in.ready = (state == ST_IDLE);
    out_load      = (state == ST_DONE) && (!out_valid || date_out.ready);
  end

  // Working registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          t     <= t0;
          y_cur <= y0;
          rem   <= rem0;
          yoe   <= '0;
          w     <= '0;
          mp    <= '0;
        end
      end
      ST_BASE: begin
        if (rem >= REM_W'(ERA_YEARS)) begin
          rem <= rem - REM_W'(ERA_YEARS);
        end
      end
      ST_PRE: begin
        // Weekday residue from the era start up to the start year.
        if (yoe != rem[YOE_W-1:0]) begin
          yoe <= yoe + YOE_W'(1);
          w   <= add_mod7(w, yadv);
        end
      end
      ST_ERA: begin
        // A whole era is a whole number of weeks, so the residue is kept.
        if (take) begin
          t     <= sum;
          y_cur <= t_neg ? (y_cur - Y_ERA) : (y_cur + Y_ERA);
        end
      end
      ST_YEAR: begin
        if (take) begin
          t     <= sum;
          y_cur <= y_cur + Y_ONE;
          yoe   <= (yoe == YOE_W'(ERA_YEARS - 1)) ? '0 : (yoe + YOE_W'(1));
          w     <= add_mod7(w, yadv);
        end
      end
      ST_MONTH: begin
        if (take) begin
          t  <= sum;
          mp <= mp + MONTH_W'(1);
          w  <= add_mod7(w, madv);
        end
      end
      default: begin
      end
    endcase
  end

  // Final date from the walk position.
  logic signed [YW-1:0] ry;
  logic                 oor;
  logic [YEAR_W-1:0]    fin_year;
  logic [MONTH_W-1:0]   fin_month;
  logic [DAY_W-1:0]     fin_day;
  logic [WEEKDAY_W-1:0] fin_wd;

  always_comb begin
    ry  = y_cur + ((mp >= MONTH_W'(MP_JAN)) ? Y_ONE : '0);
    oor = (ry < Y_LO) || (ry > Y_HI);
    if (ry < Y_LO) begin
      fin_year = YEAR_W'(YEAR_MIN);
    end else if (ry > Y_HI) begin
      fin_year = YEAR_W'(YEAR_MAX);
    end else begin
      fin_year = ry[YEAR_W-1:0];
    end
    if (mp >= MONTH_W'(MP_JAN)) begin
      fin_month = mp - MONTH_W'(MONTHS_PER_YEAR - MP_BASE_MONTH);
    end else begin
      fin_month = mp + MONTH_W'(MP_BASE_MONTH);
    end
    fin_day = t[DAY_W-1:0] + DAY_W'(1);
    fin_wd  = wrap_mod7(6'(w) + 6'(t[DAY_W-1:0]) + 6'(WEEKDAY_BIAS));
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (date_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      date_out.result_year       <= fin_year;
      date_out.result_month      <= fin_month;
      date_out.result_day        <= fin_day;
      date_out.weekday           <= fin_wd;
      date_out.year_out_of_range <= oor;
    end
  end

  assign date_out.valid = out_valid;

  // Design checks.
  `GDO_ASSERT_NEXT(a_accept_starts, clk, rst, accept, state == ST_BASE, "accepted transaction did not start the era reduction")
  `GDO_ASSERT_NOW(a_pre_bound, clk, rst, state == ST_PRE, (rem < REM_W'(ERA_YEARS)) && (yoe <= rem[YOE_W-1:0]), "year-of-era counter passed the reduced start year")
  `GDO_ASSERT_NOW(a_walk_nonneg, clk, rst, (state == ST_YEAR) || (state == ST_MONTH), !t[TW-1], "day count negative during the year or month walk")
  `GDO_ASSERT_NOW(a_month_bound, clk, rst, state == ST_MONTH, mp <= MONTH_W'(MONTHS_PER_YEAR - 1), "month walk ran past February")

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench for the Gregorian date offset block: a queue-fed driver, a
// monitor that checks each resulting date against an in-bench calendar calculation.
// Depends on gdo_pkg, gdo_in_if, gdo_out_if and the gregorian_date_offset top level.
`default_nettype none

module testbench;
  import gdo_pkg::*;

  localparam int OFFSET_BITS  = 21;
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 200;

  // One starting date with its offset; hold makes the driver wait for an empty pipeline.
  typedef struct {
    logic [YEAR_W-1:0]             year;
    logic [MONTH_W-1:0]            month;
    logic [DAY_W-1:0]              day;
    logic signed [OFFSET_BITS-1:0] offset;
    bit                            hold;
  } date_request_t;

  // One shifted date as the block reports it.
  typedef struct {
    logic [YEAR_W-1:0]    year;
    logic [MONTH_W-1:0]   month;
    logic [DAY_W-1:0]     day;
    logic [WEEKDAY_W-1:0] weekday;
    logic                 out_of_range;
  } shifted_date_t;

  logic clk;
  logic rst;

  gdo_in_if #(.OFFSET_BITS(OFFSET_BITS)) in_ch ();
  gdo_out_if out_ch ();

  gregorian_date_offset #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .date_in  (in_ch),
    .date_out (out_ch)
  );

  date_request_t pending_requests[$];
  shifted_date_t predicted_dates[$];

  int errors        = 0;
  int sent_count    = 0;
  int checked_count = 0;
  int oor_count     = 0;
  int hold_count    = 0;
  int cycle_count   = 0;
  int send_gap      = 0;
  int stall_left    = 0;

  // Clock generation.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Division rounding toward minus infinity.
  function automatic longint floor_quot(input longint a, input longint b);
    longint q;
    q = a / b;
    if ((a % b) < 0) begin
      q = q - 1;
    end
    return q;
  endfunction

  // Day number counted from 1 March of year 0, for month 1..12 and day from 1.
  function automatic longint day_serial(input longint y, input longint m, input longint d);
    longint yy, era, yoe, mi, doy;
    yy  = (m <= 2) ? y - 1 : y;
    era = floor_quot(yy, 400);
    yoe = yy - era * 400;
    mi  = (m > 2) ? m - 3 : m + 9;
    doy = (153 * mi + 2) / 5 + d - 1;
    return era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy;
  endfunction

  // Inverse of day_serial.
  function automatic void serial_to_date(input longint z, output longint y, output longint m,
                                         output longint d);
    longint era, doe, yoe, doy, mi;
    era = floor_quot(z, 146097);
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mi  = (5 * doy + 2) / 153;
    d   = doy - (153 * mi + 2) / 5 + 1;
    m   = (mi < 10) ? mi + 3 : mi - 9;
    y   = yoe + era * 400 + ((m <= 2) ? 1 : 0);
  endfunction

  // Expected result of shifting one starting date.
  function automatic shifted_date_t predict_shift(input date_request_t req);
    shifted_date_t res;
    longint m, z, ry, rm, rd;
    m = longint'(req.month);
    if (m < 1) begin
      m = 1;
    end
    if (m > 12) begin
      m = 12;
    end
    // Excess or zero days fold into neighboring months through the day count.
    z = day_serial(longint'(req.year), m, 1) + (longint'(req.day) - 1) + longint'(req.offset);
    serial_to_date(z, ry, rm, rd);
    res.weekday      = WEEKDAY_W'((z + 3) - floor_quot(z + 3, 7) * 7);
    res.out_of_range = (ry < YEAR_MIN) || (ry > YEAR_MAX);
    if (ry < YEAR_MIN) begin
      ry = YEAR_MIN;
    end
    if (ry > YEAR_MAX) begin
      ry = YEAR_MAX;
    end
    res.year  = YEAR_W'(ry);
    res.month = MONTH_W'(rm);
    res.day   = DAY_W'(rd);
    return res;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 25);
    end
    return $urandom_range(60, 250);
  endfunction

  task automatic add_request(input int y, input int m, input int d, input int off,
                             input bit hold);
    date_request_t req;
    req.year   = YEAR_W'(y);
    req.month  = MONTH_W'(m);
    req.day    = DAY_W'(d);
    req.offset = OFFSET_BITS'(off);
    req.hold   = hold;
    pending_requests.push_back(req);
  endtask

  task automatic report_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Driver: presents queued requests and predicts each accepted transaction.
  always @(posedge clk) begin : drive_requests
    date_request_t req;
    bit busy;
    if (rst) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      busy = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        predicted_dates.push_back(predict_shift(req));
        sent_count++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_requests.size() != 0 &&
                     !(pending_requests[0].hold && predicted_dates.size() != 0)) begin
          req = pending_requests.pop_front();
          if (req.hold) begin
            hold_count++;
          end
          in_ch.start_year  <= req.year;
          in_ch.start_month <= req.month;
          in_ch.start_day   <= req.day;
          in_ch.day_offset  <= req.offset;
          in_ch.valid       <= 1'b1;
          // A stretch of back-to-back transactions in the middle of the run.
          send_gap = (sent_count >= 120 && sent_count < 150) ? 0 : pick_idle();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest prediction.
  always @(posedge clk) begin : check_results
    shifted_date_t want;
    bit no_stall;
    bit next_ready;
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      no_stall = (checked_count >= 110 && checked_count < 150);
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_dates.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d-%0d-%0d wd %0d oor %0b",
                   $time, out_ch.result_year, out_ch.result_month, out_ch.result_day,
                   out_ch.weekday, out_ch.year_out_of_range);
          errors++;
        end else begin
          want = predicted_dates.pop_front();
          report_field("result_year", want.year, out_ch.result_year);
          report_field("result_month", want.month, out_ch.result_month);
          report_field("result_day", want.day, out_ch.result_day);
          report_field("weekday", want.weekday, out_ch.weekday);
          report_field("year_out_of_range", want.out_of_range, out_ch.year_out_of_range);
          if (want.out_of_range) begin
            oor_count++;
          end
        end
        checked_count++;
        if (!no_stall) begin
          stall_left = pick_idle();
        end
      end else if (stall_left == 0 && !no_stall && $urandom_range(0, 49) == 0) begin
        stall_left = pick_idle();
      end
      if (stall_left > 0) begin
        stall_left--;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      out_ch.ready <= next_ready;
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               predicted_dates.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    int y, m, d, off, mag, pick;
    rst               = 1'b1;
    in_ch.valid       = 1'b0;
    in_ch.start_year  = '0;
    in_ch.start_month = '0;
    in_ch.start_day   = '0;
    in_ch.day_offset  = '0;
    out_ch.ready      = 1'b0;

    // Directed cases: field extremes, leap rules, year wrap, folded months and days.
    add_request(2024, 1, 1, 0, 0);
    add_request(1, 1, 1, -1, 0);             // falls before year 1
    add_request(9999, 12, 31, 1, 0);         // falls after year 9999
    add_request(2023, 2, 31, 0, 1);          // day past month end, after a pause
    add_request(2024, 3, 0, 0, 0);           // day zero is the last of February
    add_request(2023, 0, 15, 0, 0);          // month zero reads as January
    add_request(2023, 13, 15, 0, 0);         // months above 12 read as December
    add_request(2023, 15, 31, 0, 0);
    add_request(0, 1, 1, 0, 0);              // year zero is a leap year
    add_request(16383, 15, 31, 1048575, 0);  // all ones, largest forward move
    add_request(16383, 1, 1, -1048576, 0);
    add_request(1, 1, 1, -1048576, 0);
    add_request(9999, 12, 31, 1048575, 0);
    add_request(1, 1, 1, 1048575, 0);
    add_request(2000, 2, 28, 1, 0);          // divisible by 400: leap
    add_request(1900, 2, 28, 1, 0);          // divisible by 100 only: common
    add_request(2100, 3, 1, -1, 0);
    add_request(2023, 12, 31, 1, 0);         // carry into the next year
    add_request(2024, 1, 1, -1, 0);          // borrow from the previous year
    add_request(2024, 1, 31, -1, 0);
    add_request(1970, 1, 1, 0, 0);
    add_request(5461, 5, 10, 699050, 0);     // alternating bit patterns
    add_request(10922, 10, 21, -699051, 0);

    // Random part, mostly valid calendar dates.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        y = $urandom_range(1, 9999);
        m = $urandom_range(1, 12);
        d = $urandom_range(1, 31);
        mag = $urandom_range(0, 2);
        if (mag == 0) begin
          off = $urandom_range(0, 400);
        end else if (mag == 1) begin
          off = $urandom_range(0, 40000);
        end else begin
          off = $urandom_range(0, 1048576);
        end
        if ($urandom_range(0, 1)) begin
          off = -off;
        end
      end else if (pick < 80) begin
        // Around the end of February in leap-rule years.
        mag = $urandom_range(0, 2);
        y = (mag == 0) ? 4 * $urandom_range(1, 2499) :
            (mag == 1) ? 100 * $urandom_range(1, 99) : 400 * $urandom_range(1, 24);
        m = $urandom_range(2, 3);
        d = (m == 2) ? $urandom_range(27, 29) : $urandom_range(0, 2);
        off = $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) begin
          off = off + 1461 * $urandom_range(0, 3);
        end
        if ($urandom_range(0, 1)) begin
          off = -off;
        end
      end else begin
        // Any field values, out-of-range months, days and years included.
        y   = $urandom_range(0, 16383);
        m   = $urandom_range(0, 15);
        d   = $urandom_range(0, 31);
        off = int'($urandom());
      end
      add_request(y, m, d, off, (i % 45) == 30);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || in_ch.valid) begin
      @(posedge clk);
    end
    while (predicted_dates.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Shifted %0d dates (%0d outside years 1..9999), %0d pauses for an empty pipe,",
             checked_count, oor_count, hold_count);
    $display("covering folded months and days, leap rules and full-range offsets.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+hdl
hdl/gdo_pkg.sv
hdl/gdo_in_if.sv
hdl/gdo_out_if.sv
hdl/gregorian_date_offset.sv
test/testbench.sv
